FILE: design/spm_pkg.sv
// Shared definitions for the substring palindrome counter.
// Holds the word types of both channels, opcodes, status codes and the modulus.
// Depends on nothing.
package spm_pkg;

    localparam int MAX_LEN_DEF  = 4096;
    localparam int ALPHABET_DEF = 26;

    localparam int OP_W     = 2;
    localparam int LETTER_W = 5;
    localparam int POS_W    = 13;
    localparam int COUNT_W  = 30;
    localparam int STATUS_W = 2;
    localparam int BIT_W    = $clog2(COUNT_W);

    localparam longint MOD_P   = 64'd1000000007;
    localparam logic [31:0] MOD_P32 = 32'd1000000007;
    localparam logic [31:0] MOD_2P  = 32'd2000000014;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [LETTER_W-1:0] letter;
        logic [POS_W-1:0]    left;
        logic [POS_W-1:0]    right;
    } in_word_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } out_word_t;

endpackage

FILE: design/substring_palindrome_multinomial.sv
// Clear, unused and rejected words go straight to ST_DONE; an append reads the last row and
// writes the next in ST_AP; a valid query reads two rows, then forms each product (inverse
// factorials, total factorial, odd count if nonzero) in ST_SEL, ST_LOAD and bit-serial ST_MUL.
// One word is in work at a time; s_ready rises together with m_valid.
// Reset is synchronous and active low; it empties the string. Row zero is never stored.
// Depends on spm_pkg for word types, opcodes, status codes and the modulus.
module substring_palindrome_multinomial #(
    parameter int MAX_LEN  = spm_pkg::MAX_LEN_DEF,
    parameter int ALPHABET = spm_pkg::ALPHABET_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  spm_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output spm_pkg::out_word_t m_data
);
    import spm_pkg::*;

    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int FD  = MAX_LEN / 2 + 1;
    localparam int FAW = $clog2(FD);
    localparam int TW  = CW + $clog2(ALPHABET);
    localparam int SW  = $clog2(ALPHABET + 2);
    localparam int OW  = $clog2(ALPHABET + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_AP   = 3'd1;
    localparam logic [2:0] ST_QHI  = 3'd2;
    localparam logic [2:0] ST_QLO  = 3'd3;
    localparam logic [2:0] ST_SEL  = 3'd4;
    localparam logic [2:0] ST_LOAD = 3'd5;
    localparam logic [2:0] ST_MUL  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    typedef logic [CW-1:0] cnt_t;
    typedef cnt_t [ALPHABET-1:0] row_t;
    typedef logic [COUNT_W-1:0] rom_t [0:FD-1];

    function automatic rom_t build_fact();
        rom_t   t;
        longint f;
        f = 1;
        for (int i = 0; i < FD; i++) begin
            if (i > 0) begin
                f = (f * longint'(i)) % MOD_P;
            end
            t[i] = COUNT_W'(f);
        end
        return t;
    endfunction

    function automatic rom_t build_inv();
        rom_t   t;
        longint f;
        longint b;
        longint e;
        longint acc;
        f = 1;
        for (int i = 1; i < FD; i++) begin
            f = (f * longint'(i)) % MOD_P;
        end
        b = f;
        e = MOD_P - 2;
        acc = 1;
        while (e != 0) begin
            if (e[0]) begin
                acc = (acc * b) % MOD_P;
            end
            b = (b * b) % MOD_P;
            e = e >> 1;
        end
        t[FD-1] = COUNT_W'(acc);
        for (int i = FD - 1; i > 0; i--) begin
            acc = (acc * longint'(i)) % MOD_P;
            t[i-1] = COUNT_W'(acc);
        end
        return t;
    endfunction

    localparam rom_t FACT_ROM = build_fact();
    localparam rom_t INV_ROM  = build_inv();

    row_t mem [0:MAX_LEN];

    logic [2:0]          state_reg;
    logic [CW-1:0]       len_reg;
    logic [LETTER_W-1:0] letter_reg;
    logic                lo_zero_reg;
    logic [CW-1:0]       lo_addr_reg;
    row_t                rd_data_reg;
    row_t                hi_reg;
    row_t                cnt_reg;
    logic [SW-1:0]       step_reg;
    logic [TW-1:0]       total_reg;
    logic [OW-1:0]       odd_reg;
    logic [COUNT_W-1:0]  acc_reg;
    logic [COUNT_W-1:0]  r_reg;
    logic [COUNT_W-1:0]  b_reg;
    logic [BIT_W-1:0]    bit_reg;
    logic [COUNT_W-1:0]  inv_q_reg;
    logic [COUNT_W-1:0]  fact_q_reg;
    out_word_t           res_reg;
    logic                m_valid_reg;
    out_word_t           m_data_reg;

    logic               range_bad;
    logic               store_full;
    logic               letter_ok;
    logic               rd_en;
    logic [CW-1:0]      rd_addr;
    logic               wr_en;
    logic [CW-1:0]      wr_addr;
    row_t               wr_row;
    cnt_t               half0;
    logic [FAW-1:0]     inv_addr;
    logic [FAW-1:0]     fact_addr;
    logic [31:0]        mul_sum;
    logic [COUNT_W-1:0] r_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign range_bad = (s_data.left == '0) || (s_data.right < s_data.left) ||
                       (32'(s_data.right) > 32'(len_reg));
    assign store_full = (32'(len_reg) >= MAX_LEN);
    assign letter_ok  = (32'(s_data.letter) < ALPHABET);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = len_reg;
        if (state_reg == ST_IDLE && s_valid) begin
            if (s_data.op == OP_QUERY) begin
                rd_en   = 1'b1;
                rd_addr = CW'(s_data.right);
            end else if (s_data.op == OP_APPEND) begin
                rd_en   = 1'b1;
                rd_addr = len_reg;
            end
        end else if (state_reg == ST_QHI) begin
            rd_en   = 1'b1;
            rd_addr = lo_addr_reg;
        end
    end

    assign wr_en   = (state_reg == ST_AP);
    assign wr_addr = len_reg + CW'(1);

    always_comb begin
        for (int c = 0; c < ALPHABET; c++) begin
            wr_row[c] = (lo_zero_reg ? '0 : rd_data_reg[c]) +
                        ((32'(letter_reg) == c) ? CW'(1) : CW'(0));
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign half0     = cnt_reg[0] >> 1;
    assign inv_addr  = (32'(half0) >= FD) ? FAW'(FD - 1) : FAW'(half0);
    assign fact_addr = (32'(total_reg) >= FD) ? FAW'(FD - 1) : FAW'(total_reg);

    always_ff @(posedge aclk) begin
        inv_q_reg  <= INV_ROM[inv_addr];
        fact_q_reg <= FACT_ROM[fact_addr];
    end

    always_comb begin
        mul_sum = {1'b0, r_reg, 1'b0} + (b_reg[COUNT_W-1] ? 32'(acc_reg) : 32'd0);
        if (mul_sum >= MOD_2P) begin
            r_next = COUNT_W'(mul_sum - MOD_2P);
        end else if (mul_sum >= MOD_P32) begin
            r_next = COUNT_W'(mul_sum - MOD_P32);
        end else begin
            r_next = COUNT_W'(mul_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        res_reg.count <= '0;
                        case (s_data.op)
                            OP_APPEND: begin
                                if (store_full) begin
                                    res_reg.status <= STAT_FULL;
                                    state_reg      <= ST_DONE;
                                end else if (letter_ok) begin
                                    res_reg.status <= STAT_OK;
                                    letter_reg     <= s_data.letter;
                                    lo_zero_reg    <= (len_reg == '0);
                                    state_reg      <= ST_AP;
                                end else begin
                                    res_reg.status <= STAT_OK;
                                    state_reg      <= ST_DONE;
                                end
                            end
                            OP_QUERY: begin
                                if (range_bad) begin
                                    res_reg.status <= STAT_BAD_RANGE;
                                    state_reg      <= ST_DONE;
                                end else begin
                                    res_reg.status <= STAT_OK;
                                    lo_zero_reg    <= (s_data.left == POS_W'(1));
                                    lo_addr_reg    <= CW'(s_data.left - POS_W'(1));
                                    state_reg      <= ST_QHI;
                                end
                            end
                            OP_CLEAR: begin
                                res_reg.status <= STAT_OK;
                                len_reg        <= '0;
                                state_reg      <= ST_DONE;
                            end
                            default: begin
                                res_reg.status <= STAT_OK;
                                state_reg      <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_AP: begin
                    len_reg   <= len_reg + CW'(1);
                    state_reg <= ST_DONE;
                end
                ST_QHI: begin
                    hi_reg    <= rd_data_reg;
                    state_reg <= ST_QLO;
                end
                ST_QLO: begin
                    for (int c = 0; c < ALPHABET; c++) begin
                        cnt_reg[c] <= hi_reg[c] - (lo_zero_reg ? '0 : rd_data_reg[c]);
                    end
                    acc_reg   <= COUNT_W'(1);
                    step_reg  <= '0;
                    total_reg <= '0;
                    odd_reg   <= '0;
                    state_reg <= ST_SEL;
                end
                ST_SEL: begin
                    if (32'(step_reg) < ALPHABET) begin
                        total_reg <= total_reg + TW'(half0);
                        odd_reg   <= odd_reg + OW'(cnt_reg[0][0]);
                        for (int c = 0; c < ALPHABET - 1; c++) begin
                            cnt_reg[c] <= cnt_reg[c+1];
                        end
                        state_reg <= ST_LOAD;
                    end else if (32'(step_reg) == ALPHABET) begin
                        state_reg <= ST_LOAD;
                    end else if (odd_reg == '0) begin
                        res_reg.count <= acc_reg;
                        state_reg     <= ST_DONE;
                    end else begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (32'(step_reg) < ALPHABET) begin
                        b_reg <= inv_q_reg;
                    end else if (32'(step_reg) == ALPHABET) begin
                        b_reg <= fact_q_reg;
                    end else begin
                        b_reg <= COUNT_W'(odd_reg);
                    end
                    r_reg     <= '0;
                    bit_reg   <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    r_reg   <= r_next;
                    b_reg   <= b_reg << 1;
                    bit_reg <= bit_reg + BIT_W'(1);
                    if (bit_reg == BIT_W'(COUNT_W - 1)) begin
                        acc_reg  <= r_next;
                        step_reg <= step_reg + SW'(1);
                        if (32'(step_reg) == ALPHABET + 1) begin
                            res_reg.count <= r_next;
                            state_reg     <= ST_DONE;
                        end else begin
                            state_reg <= ST_SEL;
                        end
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(len_reg) <= MAX_LEN)
        else $error("stored length beyond capacity");
    a_acc_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEL) |-> (32'(acc_reg) < MOD_P32))
        else $error("accumulator not reduced");
    a_r_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (32'(r_reg) < MOD_P32))
        else $error("partial product not reduced");
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word taken while one is in work");
`endif

endmodule

FILE: verif/tb_substring_palindrome_multinomial.sv
// Testbench for the substring palindrome counter: drives append, query, clear and unused words
// through the valid/ready channels and checks each result against a scoreboard predictor.
// Depends on spm_pkg and substring_palindrome_multinomial.
module tb_substring_palindrome_multinomial;
    timeunit 1ns;
    timeprecision 1ps;
    import spm_pkg::*;

    localparam int STRING_MAX = 4096;
    localparam int LETTERS    = 26;
    localparam int FACT_TOP   = STRING_MAX / 2;
    localparam int WATCH_LIMIT = 20000;

    class palindrome_scoreboard;
        bit [12:0]     prefix[0:STRING_MAX][LETTERS];
        int unsigned   length;
        longint unsigned fact[0:FACT_TOP];
        longint unsigned inv_fact[0:FACT_TOP];
        out_word_t     expected_q[$];
        int            mismatches;

        function new();
            longint unsigned acc, b;
            int e;
            length = 0;
            mismatches = 0;
            for (int c = 0; c < LETTERS; c++) prefix[0][c] = 0;
            fact[0] = 1;
            for (int i = 1; i <= FACT_TOP; i++) fact[i] = (fact[i-1] * i) % MOD_P;
            acc = 1;
            b = fact[FACT_TOP];
            e = MOD_P - 2;
            while (e != 0) begin
                if (e & 1) acc = (acc * b) % MOD_P;
                b = (b * b) % MOD_P;
                e = e >> 1;
            end
            inv_fact[FACT_TOP] = acc;
            for (int i = FACT_TOP; i > 0; i--) inv_fact[i-1] = (inv_fact[i] * i) % MOD_P;
        endfunction

        function void note_word(in_word_t w);
            out_word_t r;
            int unsigned halves, total, odd, cnt;
            longint unsigned acc;
            r.count = '0;
            r.status = STAT_OK;
            if (w.op == OP_APPEND) begin
                if (length >= STRING_MAX) begin
                    r.status = STAT_FULL;
                end else if (w.letter < LETTERS) begin
                    prefix[length+1] = prefix[length];
                    prefix[length+1][w.letter] = prefix[length][w.letter] + 13'd1;
                    length++;
                end
            end else if (w.op == OP_QUERY) begin
                if (w.left < 1 || w.right < w.left || w.right > length) begin
                    r.status = STAT_BAD_RANGE;
                end else begin
                    total = 0;
                    odd = 0;
                    for (int c = 0; c < LETTERS; c++)
                        total += (prefix[w.right][c] - prefix[w.left-1][c]) >> 1;
                    if (total > FACT_TOP) total = FACT_TOP;
                    acc = fact[total];
                    for (int c = 0; c < LETTERS; c++) begin
                        cnt = prefix[w.right][c] - prefix[w.left-1][c];
                        if (cnt & 1) odd++;
                        halves = cnt >> 1;
                        if (halves > FACT_TOP) halves = FACT_TOP;
                        acc = (acc * inv_fact[halves]) % MOD_P;
                    end
                    if (odd > 0) acc = (acc * odd) % MOD_P;
                    r.count = acc[COUNT_W-1:0];
                end
            end else if (w.op == OP_CLEAR) begin
                length = 0;
            end
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void check_word(out_word_t got);
            out_word_t exp_w;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word: count %0d status %0d",
                             got.count, got.status);
                return;
            end
            exp_w = expected_q.pop_front();
            if (got.count !== exp_w.count || got.status !== exp_w.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected count %0d status %0d, got count %0d status %0d",
                             exp_w.count, exp_w.status, got.count, got.status);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    palindrome_scoreboard sb;
    bit  hold_request;
    bit  sender_fast;
    bit  receiver_fast;
    int  quiet_cycles = 0;

    substring_palindrome_multinomial DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_word(s_data);
            if (m_valid && m_ready) sb.check_word(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_word(input in_word_t w);
        int gap;
        gap = sender_fast ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data = w;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input int letter, input int lo,
                           input int hi);
        in_word_t w;
        w.op = op;
        w.letter = LETTER_W'(letter);
        w.left = POS_W'(lo);
        w.right = POS_W'(hi);
        send_word(w);
    endtask

    task automatic random_word();
        int pick, len, lo, hi;
        len = sb.length;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            send_op(OP_APPEND, ($urandom_range(0, 19) == 0) ? $urandom_range(26, 31)
                                                             : $urandom_range(0, 25), 0, 0);
        end else if (pick < 85 && len > 0) begin
            lo = $urandom_range(1, len);
            hi = $urandom_range(lo, len);
            send_op(OP_QUERY, $urandom_range(0, 31), lo, hi);
        end else if (pick < 93) begin
            send_op(OP_QUERY, $urandom_range(0, 31), $urandom_range(0, 8191),
                    $urandom_range(0, 8191));
        end else if (pick < 97) begin
            send_op(OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 8191),
                    $urandom_range(0, 8191));
        end else begin
            send_op(OP_UNUSED, $urandom_range(0, 31), $urandom_range(0, 8191),
                    $urandom_range(0, 8191));
        end
    endtask

    initial begin
        int gap, hold;
        bit held;
        held = 1'b0;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (hold_request && !held) begin
                m_ready = 1'b0;
                hold = 0;
                while (hold < 3000) begin
                    @(negedge aclk);
                    hold++;
                end
                held = 1'b1;
            end
            gap = receiver_fast ? 0 : $urandom_range(0, 15);
            if (gap != 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        hold_request = 1'b0;
        sender_fast = 1'b0;
        receiver_fast = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_op(OP_QUERY, 0, 1, 1);
        send_op(OP_APPEND, 0, 0, 0);
        send_op(OP_APPEND, 25, 0, 0);
        send_op(OP_APPEND, 26, 0, 0);
        send_op(OP_APPEND, 31, 0, 0);
        send_op(OP_APPEND, 0, 0, 0);
        send_op(OP_APPEND, 25, 0, 0);
        send_op(OP_APPEND, 7, 0, 0);
        send_op(OP_QUERY, 0, 1, 5);
        send_op(OP_QUERY, 0, 2, 2);
        send_op(OP_QUERY, 0, 1, 4);
        send_op(OP_QUERY, 0, 0, 3);
        send_op(OP_QUERY, 0, 4, 3);
        send_op(OP_QUERY, 0, 1, 6);
        send_op(OP_QUERY, 31, 8191, 8191);
        send_op(OP_UNUSED, 31, 8191, 8191);
        send_op(OP_CLEAR, 0, 0, 0);
        send_op(OP_QUERY, 0, 1, 1);

        send_op(OP_QUERY, 0, 1, 4096);
        send_op(OP_QUERY, 0, 1, 2048);
        send_op(OP_QUERY, 0, 4096, 4096);
        send_op(OP_APPEND, 3, 0, 0);
        send_op(OP_QUERY, 0, 1, 4097);
        send_op(OP_CLEAR, 0, 0, 0);

        for (int i = 0; i < 1620; i++) begin
            if (i % 100 == 0) begin
                sender_fast = ($urandom_range(0, 3) == 0);
                receiver_fast = ($urandom_range(0, 3) == 0);
            end
            if (i == 400) hold_request = 1'b1;
            if (i == 800 || i == 1200) begin
                s_valid = 1'b0;
                while (sb.pending() != 0) @(negedge aclk);
            end
            random_word();
        end
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

FILE: filelist.f
design/spm_pkg.sv
design/substring_palindrome_multinomial.sv
verif/tb_substring_palindrome_multinomial.sv
